// ----- design/dlab_pkg.sv -----
// Shared types, constants and byte-selection functions for the DNS local answer builder.
package dlab_pkg;

	localparam int unsigned MAX_MESSAGE  = 512;
	localparam int unsigned ANSWER_BYTES = 16;
	localparam int unsigned MIN_QUERY    = 17;
	localparam int unsigned POS_W        = 10;
	localparam int unsigned LEN_W        = POS_W + 1;
	localparam int unsigned IDX_W        = $clog2(ANSWER_BYTES);
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = QPTR_W + 1;

	localparam logic [POS_W-1:0] POS_LIMIT      = '1;
	localparam logic [LEN_W-1:0] LEN_LIMIT      = LEN_W'(MAX_MESSAGE - ANSWER_BYTES);
	localparam logic [LEN_W-1:0] LEN_MIN        = LEN_W'(MIN_QUERY);
	localparam logic [IDX_W-1:0] ANSWER_LAST    = IDX_W'(ANSWER_BYTES - 1);
	localparam logic [31:0]      TTL_RESET      = 32'd240;
	localparam logic [31:0]      QTAIL_EXPECT   = 32'h0001_0001;

	localparam logic [POS_W-1:0] POS_FLAGS_HI   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_FLAGS_LO   = POS_W'(3);
	localparam logic [POS_W-1:0] POS_QDCOUNT_HI = POS_W'(4);
	localparam logic [POS_W-1:0] POS_QDCOUNT_LO = POS_W'(5);
	localparam logic [POS_W-1:0] POS_ANCOUNT_HI = POS_W'(6);
	localparam logic [POS_W-1:0] POS_ANCOUNT_LO = POS_W'(7);

	localparam logic [7:0] PATCH_FLAGS_HI   = 8'h85;
	localparam logic [7:0] PATCH_FLAGS_LO   = 8'h80;
	localparam logic [7:0] PATCH_ANCOUNT_LO = 8'h01;
	localparam logic [7:0] NAME_PTR_HI      = 8'hC0;
	localparam logic [7:0] NAME_PTR_LO      = 8'h0C;
	localparam logic [7:0] RDLENGTH_LO      = 8'h04;
	localparam logic [7:0] BYTE_ZERO        = 8'h00;
	localparam logic [7:0] BYTE_ONE         = 8'h01;

	typedef struct packed {
		logic [7:0]  query_byte;
		logic        query_end;
		logic        answer_kind;
		logic [31:0] answer_address;
	} query_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       reply_end;
		logic       keep;
	} reply_t;

	typedef struct packed {
		logic [7:0]  rbyte;
		logic        last;
		logic        keep;
		logic [31:0] addr;
	} dlab_entry_t;

	function automatic logic [7:0] query_patch(logic [POS_W-1:0] pos, logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (pos == POS_FLAGS_HI) begin
			r = PATCH_FLAGS_HI;
		end else if (pos == POS_FLAGS_LO) begin
			r = PATCH_FLAGS_LO;
		end else if (pos == POS_ANCOUNT_LO) begin
			r = PATCH_ANCOUNT_LO;
		end
		return r;
	endfunction

	function automatic logic header_ok(logic [POS_W-1:0] pos, logic [7:0] b);
		logic ok;
		ok = 1'b1;
		if (pos == POS_FLAGS_HI || pos == POS_QDCOUNT_LO) begin
			ok = (b == BYTE_ONE);
		end else if (pos == POS_FLAGS_LO || pos == POS_QDCOUNT_HI ||
			     pos == POS_ANCOUNT_HI || pos == POS_ANCOUNT_LO) begin
			ok = (b == BYTE_ZERO);
		end
		return ok;
	endfunction

	function automatic logic [7:0] answer_byte(logic [IDX_W-1:0] idx, logic [31:0] ttl,
						  logic [31:0] addr);
		logic [7:0] r;
		unique case (idx)
			4'd0:  r = NAME_PTR_HI;
			4'd1:  r = NAME_PTR_LO;
			4'd2:  r = BYTE_ZERO;
			4'd3:  r = BYTE_ONE;
			4'd4:  r = BYTE_ZERO;
			4'd5:  r = BYTE_ONE;
			4'd6:  r = ttl[31:24];
			4'd7:  r = ttl[23:16];
			4'd8:  r = ttl[15:8];
			4'd9:  r = ttl[7:0];
			4'd10: r = BYTE_ZERO;
			4'd11: r = RDLENGTH_LO;
			4'd12: r = addr[31:24];
			4'd13: r = addr[23:16];
			4'd14: r = addr[15:8];
			4'd15: r = addr[7:0];
		endcase
		return r;
	endfunction

endpackage

// ----- design/dlab_front.sv -----
// Front end: accepts query bytes, tracks header, tail and length, classifies each byte.
module dlab_front import dlab_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        query_valid,
	output logic        query_stall,
	input  query_t      query,
	input  logic        q_full,
	output logic        push,
	output dlab_entry_t push_entry
);

	logic [POS_W-1:0] pos_q;
	logic             hdr_good_q;
	logic [31:0]      tail_q;
	logic             ovf_q;

	logic             hdr_next;
	logic [31:0]      tail_next;
	logic [LEN_W-1:0] len;
	logic             ovf_next;

	assign query_stall = q_full;
	assign push        = query_valid & ~q_full;

	always_comb begin
		hdr_next  = hdr_good_q & header_ok(pos_q, query.query_byte);
		tail_next = {tail_q[23:0], query.query_byte};
		len       = {1'b0, pos_q} + LEN_W'(1);
		ovf_next  = ovf_q | (len > LEN_LIMIT);
		push_entry.rbyte = query_patch(pos_q, query.query_byte);
		push_entry.last  = query.query_end;
		push_entry.keep  = hdr_next & ~ovf_next & (len >= LEN_MIN) &
				   (tail_next == QTAIL_EXPECT);
		push_entry.addr  = query.answer_kind ? 32'd0 : query.answer_address;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			hdr_good_q <= 1'b1;
			tail_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (push) begin
			if (query.query_end) begin
				pos_q      <= '0;
				hdr_good_q <= 1'b1;
				tail_q     <= '0;
				ovf_q      <= 1'b0;
			end else begin
				if (pos_q != POS_LIMIT) begin
					pos_q <= pos_q + POS_W'(1);
				end
				hdr_good_q <= hdr_next;
				tail_q     <= tail_next;
				ovf_q      <= ovf_next;
			end
		end
	end

endmodule

// ----- design/dlab_fifo.sv -----
// Short queue of classified bytes between the front and back ends.
module dlab_fifo import dlab_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  dlab_entry_t push_entry,
	input  logic        pop,
	output logic        full,
	output logic        empty,
	output dlab_entry_t head
);

	dlab_entry_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- design/dlab_back.sv -----
// Back end: emits patched query bytes and appends the A answer record after the last one.
module dlab_back import dlab_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        answer_ttl_we,
	input  logic [31:0] answer_ttl_data,
	input  logic        q_empty,
	input  dlab_entry_t head,
	output logic        pop,
	output logic        reply_valid,
	input  logic        reply_stall,
	output reply_t      reply
);

	logic [31:0]      ttl_q;
	logic             ans_act_q;
	logic [IDX_W-1:0] idx_q;
	logic             keep_q;
	logic [31:0]      addr_q;
	logic             out_valid_q;
	reply_t           out_q;
	logic             load;

	assign load        = ~out_valid_q | ~reply_stall;
	assign pop         = load & ~ans_act_q & ~q_empty;
	assign reply_valid = out_valid_q;
	assign reply       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (answer_ttl_we) begin
			ttl_q <= answer_ttl_data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			keep_q <= head.keep;
			addr_q <= head.addr;
		end
		if (load) begin
			if (ans_act_q) begin
				out_q.reply_byte <= answer_byte(idx_q, ttl_q, addr_q);
				out_q.reply_end  <= (idx_q == ANSWER_LAST);
				out_q.keep       <= (idx_q == ANSWER_LAST) & keep_q;
			end else begin
				out_q.reply_byte <= head.rbyte;
				out_q.reply_end  <= 1'b0;
				out_q.keep       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ans_act_q   <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			if (ans_act_q) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + IDX_W'(1);
				if (idx_q == ANSWER_LAST) begin
					ans_act_q <= 1'b0;
				end
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				idx_q       <= '0;
				ans_act_q   <= head.last;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/dns_local_answer_builder.sv -----
// Top level of the DNS local answer builder: front end, queue and back end.
// Path: a query byte passes through the queue and then the back end output register.
// Throughput: one query byte per cycle while not stalled; as the back end emits the
// 16-byte answer record, the front end fills a four-entry queue and then stalls.
// Reset: arst_n clears frame state and queue, and sets answer_ttl to 240.
module dns_local_answer_builder import dlab_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        query_valid,
	output logic        query_stall,
	input  query_t      query,
	output logic        reply_valid,
	input  logic        reply_stall,
	output reply_t      reply,
	input  logic        answer_ttl_we,
	input  logic [31:0] answer_ttl_data
);

	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_empty;
	dlab_entry_t push_entry;
	dlab_entry_t head;

	dlab_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_stall (query_stall),
		.query       (query),
		.q_full      (q_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	dlab_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (head)
	);

	dlab_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.answer_ttl_we   (answer_ttl_we),
		.answer_ttl_data (answer_ttl_data),
		.q_empty         (q_empty),
		.head            (head),
		.pop             (pop),
		.reply_valid     (reply_valid),
		.reply_stall     (reply_stall),
		.reply           (reply)
	);

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for dns_local_answer_builder against a local answer predictor.
`timescale 1ns / 100ps

module tb;
	import dlab_pkg::*;

	localparam logic KIND_ANSWER   = 1'b0;
	localparam logic KIND_REJECT   = 1'b1;
	localparam int   STALL_LIMIT   = 4000;
	localparam int   SETTLE_CYCLES = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        query_valid;
	logic        query_stall;
	query_t      query;
	logic        reply_valid;
	logic        reply_stall;
	reply_t      reply;
	logic        answer_ttl_we;
	logic [31:0] answer_ttl_data;

	dns_local_answer_builder uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.query_valid     (query_valid),
		.query_stall     (query_stall),
		.query           (query),
		.reply_valid     (reply_valid),
		.reply_stall     (reply_stall),
		.reply           (reply),
		.answer_ttl_we   (answer_ttl_we),
		.answer_ttl_data (answer_ttl_data)
	);

	always #2 clk = ~clk;

	// answer builder state, tracked per accepted query byte
	logic [31:0]      ttl_value = TTL_RESET;
	logic [POS_W-1:0] frame_pos = '0;
	logic             frame_header_ok = 1'b1;
	logic [31:0]      question_tail = '0;
	logic             frame_too_long = 1'b0;

	reply_t     expected_replies[$];
	logic [7:0] frame_bytes[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int queries_sent = 0;
	int bytes_sent = 0;
	int replies_checked = 0;
	int frames_kept = 0;
	int quiet_cycles = 0;
	reply_t want;

	function automatic void push_reply(logic [7:0] b, logic fin, logic kp);
		reply_t r;
		r.reply_byte = b;
		r.reply_end  = fin;
		r.keep       = kp;
		expected_replies.insert(expected_replies.size(), r);
	endfunction

	function automatic void add_byte(logic [7:0] b);
		frame_bytes.insert(frame_bytes.size(), b);
	endfunction

	function automatic void build_answer(query_t q);
		logic [POS_W-1:0] at;
		logic [LEN_W-1:0] len;
		logic [7:0]       out_byte;
		logic [31:0]      addr;
		logic [127:0]     record;
		logic             kp;
		at = frame_pos;
		len = LEN_W'(at) + 1'b1;
		if ((at == POS_FLAGS_HI || at == POS_QDCOUNT_LO) && q.query_byte != BYTE_ONE)
			frame_header_ok = 1'b0;
		if ((at == POS_FLAGS_LO || at == POS_QDCOUNT_HI || at == POS_ANCOUNT_HI ||
		     at == POS_ANCOUNT_LO) && q.query_byte != BYTE_ZERO)
			frame_header_ok = 1'b0;
		out_byte = q.query_byte;
		if (at == POS_FLAGS_HI)
			out_byte = PATCH_FLAGS_HI;
		else if (at == POS_FLAGS_LO)
			out_byte = PATCH_FLAGS_LO;
		else if (at == POS_ANCOUNT_LO)
			out_byte = PATCH_ANCOUNT_LO;
		question_tail = {question_tail[23:0], q.query_byte};
		if (len > LEN_LIMIT)
			frame_too_long = 1'b1;
		if (at != POS_LIMIT)
			frame_pos = at + 1'b1;
		push_reply(out_byte, 1'b0, 1'b0);
		if (!q.query_end)
			return;
		kp = frame_header_ok && !frame_too_long && len >= LEN_MIN &&
		     question_tail == QTAIL_EXPECT;
		addr = (q.answer_kind == KIND_REJECT) ? 32'd0 : q.answer_address;
		record = {NAME_PTR_HI, NAME_PTR_LO, BYTE_ZERO, BYTE_ONE, BYTE_ZERO, BYTE_ONE,
			  ttl_value, BYTE_ZERO, RDLENGTH_LO, addr};
		for (int i = 0; i < ANSWER_BYTES; i++) begin
			push_reply(record[127 - 8 * i -: 8], i == ANSWER_BYTES - 1,
				   (i == ANSWER_BYTES - 1) && kp);
		end
		if (kp)
			frames_kept++;
		frame_pos = '0;
		frame_header_ok = 1'b1;
		question_tail = '0;
		frame_too_long = 1'b0;
	endfunction

	always @(negedge clk) begin
		reply_stall = ($urandom_range(99, 0) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && reply_valid && !reply_stall) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected reply, expected none, actual %02h end %b keep %b",
					 $time, reply.reply_byte, reply.reply_end, reply.keep);
				errors++;
			end else begin
				want = expected_replies[0];
				expected_replies.delete(0);
				replies_checked++;
				if (reply.reply_byte !== want.reply_byte) begin
					$display("%0t: reply_byte expected %02h actual %02h",
						 $time, want.reply_byte, reply.reply_byte);
					errors++;
				end
				if (reply.reply_end !== want.reply_end) begin
					$display("%0t: reply_end expected %b actual %b",
						 $time, want.reply_end, reply.reply_end);
					errors++;
				end
				if (reply.keep !== want.keep) begin
					$display("%0t: keep expected %b actual %b",
						 $time, want.keep, reply.keep);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((query_valid && !query_stall) || (reply_valid && !reply_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles with no transaction", quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin, input logic kind,
				 input logic [31:0] addr);
		query_t item;
		item.query_byte     = b;
		item.query_end      = fin;
		item.answer_kind    = kind;
		item.answer_address = addr;
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			query_valid = 1'b0;
			@(negedge clk);
		end
		query = item;
		query_valid = 1'b1;
		do
			@(posedge clk);
		while (query_stall);
		build_answer(item);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic kind, input logic [31:0] addr);
		int last_idx;
		last_idx = frame_bytes.size() - 1;
		for (int i = 0; i <= last_idx; i++) begin
			if (i == last_idx)
				send_byte(frame_bytes[i], 1'b1, kind, addr);
			else
				send_byte(frame_bytes[i], 1'b0, 1'($urandom_range(1, 0)), $urandom);
		end
		queries_sent++;
	endtask

	task automatic build_frame(input int name_len);
		frame_bytes.delete();
		add_byte(8'($urandom_range(255, 0)));
		add_byte(8'($urandom_range(255, 0)));
		add_byte(BYTE_ONE);
		add_byte(BYTE_ZERO);
		add_byte(BYTE_ZERO);
		add_byte(BYTE_ONE);
		add_byte(BYTE_ZERO);
		add_byte(BYTE_ZERO);
		repeat (4 + name_len) add_byte(8'($urandom_range(255, 0)));
		add_byte(BYTE_ZERO);
		add_byte(BYTE_ONE);
		add_byte(BYTE_ZERO);
		add_byte(BYTE_ONE);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		query_valid = 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_ttl(input logic [31:0] value);
		wait_drained();
		@(negedge clk);
		answer_ttl_we = 1'b1;
		answer_ttl_data = value;
		@(negedge clk);
		answer_ttl_we = 1'b0;
		ttl_value = value;
	endtask

	task automatic test_default_answer();
		build_frame(1);
		send_frame(KIND_ANSWER, 32'hFFFF_FFFF);
	endtask

	task automatic test_header_extremes();
		frame_bytes.delete();
		repeat (17) add_byte(8'hFF);
		send_frame(KIND_ANSWER, 32'hFFFF_FFFF);
		frame_bytes.delete();
		repeat (17) add_byte(8'h00);
		send_frame(KIND_ANSWER, 32'h0000_0000);
	endtask

	task automatic test_reject_answer();
		build_frame(5);
		send_frame(KIND_REJECT, 32'hDEAD_BEEF);
	endtask

	task automatic test_short_queries();
		frame_bytes.delete();
		add_byte(8'hA5);
		send_frame(KIND_REJECT, $urandom);
		build_frame(0);
		send_frame(KIND_ANSWER, $urandom);
	endtask

	task automatic test_bad_question();
		build_frame(3);
		frame_bytes[frame_bytes.size() - 3] = 8'h1C;
		send_frame(KIND_ANSWER, $urandom);
		build_frame(3);
		frame_bytes[frame_bytes.size() - 1] = 8'h03;
		send_frame(KIND_ANSWER, $urandom);
	endtask

	task automatic test_ttl_extremes();
		write_ttl(32'h0000_0000);
		build_frame(2);
		send_frame(KIND_ANSWER, $urandom);
		write_ttl(32'hFFFF_FFFF);
		build_frame(2);
		send_frame(KIND_ANSWER, $urandom);
	endtask

	task automatic test_random_queries(input int byte_goal);
		int start;
		int pick;
		int cut;
		int spot;
		write_ttl($urandom);
		start = bytes_sent;
		while (bytes_sent - start < byte_goal) begin
			pick = $urandom_range(99, 0);
			build_frame($urandom_range(8, 1));
			if (pick >= 70 && pick < 80) begin
				spot = $urandom_range(frame_bytes.size() - 1, 0);
				frame_bytes[spot] = 8'($urandom_range(255, 0));
			end else if (pick >= 80 && pick < 90) begin
				cut = $urandom_range(24, 1);
				frame_bytes.delete();
				repeat (cut) add_byte(8'($urandom_range(255, 0)));
			end else if (pick >= 90) begin
				cut = $urandom_range(16, 1);
				while (frame_bytes.size() > cut)
					frame_bytes.delete(frame_bytes.size() - 1);
			end
			send_frame(1'($urandom_range(1, 0)), $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		query_valid = 1'b0;
		query = '0;
		reply_stall = 1'b0;
		answer_ttl_we = 1'b0;
		answer_ttl_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 6;
		recv_stall_pct = 60;
		test_default_answer();
		test_header_extremes();
		test_reject_answer();
		test_short_queries();
		test_bad_question();
		test_ttl_extremes();
		test_random_queries(20);

		wait_drained();
		send_idle_pct = 60;
		recv_stall_pct = 6;
		test_random_queries(20);

		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_queries(20);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d queries (%0d query bytes), %0d reply bytes checked",
			 queries_sent, bytes_sent, replies_checked);
		$display("%0d frames kept; short, malformed and rejected frames included",
			 frames_kept);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
